/* rtl/smcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smcp_pkg;

   localparam int BUFFER_SIZE = 12;
   localparam int CNT_W       = $clog2(BUFFER_SIZE);
   localparam int IDLE_W      = 16;
   localparam int DATA_W      = 8;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(BUFFER_SIZE - 1);
   localparam logic [IDLE_W-1:0] IDLE_MAX   = '1;
   localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd80;
   localparam logic [7:0]        DUTY_MAX   = 8'd255;

   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO = 8'd32;
   localparam logic [7:0] CH_PRINT_HI = 8'd126;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_F_UP     = 8'h46;
   localparam logic [7:0] CH_F_LO     = 8'h66;
   localparam logic [7:0] CH_S_UP     = 8'h53;
   localparam logic [7:0] CH_S_LO     = 8'h73;
   localparam logic [7:0] CH_QUERY    = 8'h3F;
   localparam logic [7:0] CH_H_UP     = 8'h48;
   localparam logic [7:0] CH_H_LO     = 8'h68;

   typedef enum logic {
      REQ_BYTE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      EV_STATUS  = 2'd0,
      EV_HELP    = 2'd1,
      EV_INVALID = 2'd2
   } event_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [DATA_W-1:0] data;
   } req_item_type;

   typedef struct packed {
      logic [7:0] enable_duty;
      logic       bridge_in2;
      logic       bridge_in1;
      logic [7:0] duty_setting;
      logic       forward_on;
      event_type  event_code;
   } rsp_item_type;

endpackage

`default_nettype wire

/* rtl/smcp_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module smcp_in_reg
   import smcp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_item_type in_item,
   input  wire logic         advance,
   output logic              held_valid,
   output req_item_type      held_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

`default_nettype wire

/* rtl/smcp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module smcp_core
   import smcp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire req_item_type      item,
   input  wire logic [IDLE_W-1:0] idle_limit,
   output logic                   res_valid,
   output rsp_item_type           res_item
);

   logic [CNT_W-1:0]  char_count_ff, char_count_in;
   logic [7:0]        lead_char_ff, lead_char_in;
   logic              all_digits_ff, all_digits_in;
   logic [7:0]        digit_value_ff, digit_value_in;
   logic [IDLE_W-1:0] idle_ticks_ff, idle_ticks_in;
   logic              mode_forward_ff, mode_forward_in;
   logic [7:0]        duty_value_ff, duty_value_in;

   logic              pending;
   logic              is_term;
   logic              is_print;
   logic              is_digit;
   logic              execute;
   logic [11:0]       acc;
   logic [IDLE_W-1:0] idle_next;
   event_type         ev;
   logic              drive;

   assign pending  = char_count_ff != '0;
   assign is_term  = item.data == CH_LF || item.data == CH_CR;
   assign is_print = item.data >= CH_PRINT_LO && item.data <= CH_PRINT_HI;
   assign is_digit = item.data >= CH_ZERO && item.data <= CH_NINE;
   // value * 10 as two shifts
   assign acc = {1'b0, digit_value_ff, 3'b000} + {3'b000, digit_value_ff, 1'b0}
              + {8'd0, item.data[3:0]};
   assign idle_next = (idle_ticks_ff != IDLE_MAX) ? idle_ticks_ff + 1'b1 : idle_ticks_ff;

   always_comb begin
      execute = 1'b0;
      unique case (item.kind)
         REQ_BYTE: execute = is_term && pending;
         REQ_TICK: execute = pending && idle_next >= idle_limit;
         default:  execute = 1'b0;
      endcase
   end

   always_comb begin
      char_count_in   = char_count_ff;
      lead_char_in    = lead_char_ff;
      all_digits_in   = all_digits_ff;
      digit_value_in  = digit_value_ff;
      idle_ticks_in   = idle_ticks_ff;
      mode_forward_in = mode_forward_ff;
      duty_value_in   = duty_value_ff;
      ev              = EV_STATUS;

      if (execute) begin
         priority if (lead_char_ff == CH_F_UP || lead_char_ff == CH_F_LO) begin
            mode_forward_in = 1'b1;
         end else if (lead_char_ff == CH_S_UP || lead_char_ff == CH_S_LO) begin
            mode_forward_in = 1'b0;
         end else if (lead_char_ff == CH_QUERY || lead_char_ff == CH_H_UP
                      || lead_char_ff == CH_H_LO) begin
            ev = EV_HELP;
         end else if (all_digits_ff) begin
            duty_value_in = digit_value_ff;
         end else begin
            ev = EV_INVALID;
         end
         char_count_in  = '0;
         lead_char_in   = '0;
         all_digits_in  = 1'b1;
         digit_value_in = '0;
         idle_ticks_in  = '0;
      end else if (item.kind == REQ_TICK) begin
         if (pending) begin
            idle_ticks_in = idle_next;
         end
      end else if (!is_term && is_print && char_count_ff < CNT_LIMIT) begin
         if (!pending) begin
            lead_char_in = item.data;
         end
         if (is_digit) begin
            digit_value_in = (acc > 12'(DUTY_MAX)) ? DUTY_MAX : acc[7:0];
         end else begin
            all_digits_in = 1'b0;
         end
         char_count_in = char_count_ff + 1'b1;
         idle_ticks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff   <= '0;
         lead_char_ff    <= '0;
         all_digits_ff   <= 1'b1;
         digit_value_ff  <= '0;
         idle_ticks_ff   <= '0;
         mode_forward_ff <= 1'b0;
         duty_value_ff   <= '0;
      end else if (fire) begin
         char_count_ff   <= char_count_in;
         lead_char_ff    <= lead_char_in;
         all_digits_ff   <= all_digits_in;
         digit_value_ff  <= digit_value_in;
         idle_ticks_ff   <= idle_ticks_in;
         mode_forward_ff <= mode_forward_in;
         duty_value_ff   <= duty_value_in;
      end
   end

   assign drive     = mode_forward_in && duty_value_in != '0;
   assign res_valid = execute;

   always_comb begin
      res_item.event_code   = ev;
      res_item.forward_on   = mode_forward_in;
      res_item.duty_setting = duty_value_in;
      res_item.bridge_in1   = drive;
      res_item.bridge_in2   = 1'b0;
      res_item.enable_duty  = drive ? duty_value_in : 8'd0;
   end

endmodule

`default_nettype wire

/* rtl/serial_motor_command_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Serial motor command parser. Each item is a received character or a millisecond
// tick; a command ends on CR or LF or after csr_data ticks of idle line, and gives
// one result item with the event code, the mode and the bridge drive. One item is
// taken every clock cycle while the rsp side does not stall; an item passes an input
// register and the parser state update, and its result is registered for the rsp side. A
// stalled rsp side holds req_tready low once both registers are full.
module serial_motor_command_parser
   import smcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // rx_byte
   input  wire logic                  req_tuser,  // req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // event_code[1:0], forward_on, duty_setting[7:0], bridge_in1, bridge_in2,
   // enable_duty[7:0], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [IDLE_W-1:0]     csr_data
);

   logic              advance;
   logic              held_valid;
   req_item_type      req_item;
   req_item_type      held_item;
   logic              fire;
   logic              res_valid;
   rsp_item_type      res_item;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_item_ff;
   logic [IDLE_W-1:0] idle_limit_ff;

   assign req_item.kind = req_kind_type'(req_tuser);
   assign req_item.data = req_tdata;

   assign advance = !out_valid_ff || rsp_tready;
   assign fire    = held_valid && advance;

   smcp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   smcp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (held_item),
      .idle_limit (idle_limit_ff),
      .res_valid  (res_valid),
      .res_item   (res_item)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_RESET;
      end else if (csr_valid) begin
         idle_limit_ff <= csr_data;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         out_item_ff <= res_item;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_item_type)){1'b0}}, out_item_ff};

   // input side only stalls behind a full, stalled result register
   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without output stall");

   a_drive_needs_forward : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_item_ff.bridge_in1) |->
         (out_item_ff.forward_on && out_item_ff.enable_duty == out_item_ff.duty_setting
          && out_item_ff.duty_setting != 8'd0))
      else $error("bridge drive inconsistent with mode and duty");

   a_no_drive_zero_enable : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_item_ff.bridge_in1) |-> (out_item_ff.enable_duty == 8'd0))
      else $error("enable duty set while not driving");

   a_result_from_item : assert property (@(posedge clock) disable iff (reset)
      (!$past(held_valid) && $past(out_valid_ff) && $past(rsp_tready)) |-> !rsp_tvalid)
      else $error("result appeared without a processed item");

endmodule

`default_nettype wire

/* tb/serial_motor_command_parser_tb.sv */
`timescale 1ns / 1ps

module serial_motor_command_parser_tb;
   import smcp_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 800;
   localparam int RSP_FIELDS_W = $bits(rsp_item_type);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [IDLE_W-1:0]     csr_data = '0;

   serial_motor_command_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // parser state as the block should hold it
   int          pend_count;
   logic [7:0]  pend_lead;
   logic        pend_digits;
   logic [7:0]  pend_value;
   logic [15:0] pend_idle;
   logic        motor_fwd;
   logic [7:0]  motor_duty;
   logic [15:0] idle_limit;

   rsp_item_type command_results_q [$];

   int cycle_count = 0;
   int mismatches  = 0;
   int items_used  = 0;
   int hold_left   = 0;
   int stall_left  = 0;
   bit tx_gaps_on  = 1'b1;
   bit rx_stalls_on = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("serial_motor_command_parser_tb: done, errors");
      $finish;
   end

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 200)
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void clear_command();
      pend_count  = 0;
      pend_lead   = '0;
      pend_digits = 1'b1;
      pend_value  = '0;
      pend_idle   = '0;
   endfunction

   function automatic void execute_command();
      event_type    ev;
      rsp_item_type res;
      if (pend_lead == CH_F_UP || pend_lead == CH_F_LO) begin
         motor_fwd = 1'b1;
         ev = EV_STATUS;
      end else if (pend_lead == CH_S_UP || pend_lead == CH_S_LO) begin
         motor_fwd = 1'b0;
         ev = EV_STATUS;
      end else if (pend_lead == CH_QUERY || pend_lead == CH_H_UP || pend_lead == CH_H_LO) begin
         ev = EV_HELP;
      end else if (pend_digits) begin
         motor_duty = pend_value;
         ev = EV_STATUS;
      end else begin
         ev = EV_INVALID;
      end
      clear_command();
      res.event_code   = ev;
      res.forward_on   = motor_fwd;
      res.duty_setting = motor_duty;
      res.bridge_in1   = motor_fwd && motor_duty != 0;
      res.bridge_in2   = 1'b0;
      res.enable_duty  = res.bridge_in1 ? motor_duty : 8'd0;
      command_results_q.push_back(res);
   endfunction

   // returns 1 when the item changed the parser state or ran a command
   function automatic bit parse_item(req_kind_type kind, logic [7:0] ch);
      int nxt;
      if (kind == REQ_BYTE) begin
         if (ch == CH_LF || ch == CH_CR) begin
            if (pend_count == 0)
               return 1'b0;
            execute_command();
            return 1'b1;
         end
         if (ch < CH_PRINT_LO || ch > CH_PRINT_HI || pend_count >= BUFFER_SIZE - 1)
            return 1'b0;
         if (pend_count == 0)
            pend_lead = ch;
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            nxt = int'(pend_value) * 10 + int'(ch - CH_ZERO);
            pend_value = (nxt > 255) ? DUTY_MAX : nxt[7:0];
         end else begin
            pend_digits = 1'b0;
         end
         pend_count++;
         pend_idle = '0;
         return 1'b1;
      end
      if (pend_count == 0)
         return 1'b0;
      if (pend_idle != IDLE_MAX)
         pend_idle++;
      if (pend_idle >= idle_limit)
         execute_command();
      return 1'b1;
   endfunction

   // result side: random stalls plus the long hold requested by a test
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 19) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (command_results_q.size() == 0) begin
            report_mismatch("result with no command run, event_code", got.event_code, -1);
         end else begin
            want = command_results_q.pop_front();
            if (got.event_code !== want.event_code)
               report_mismatch("event_code", got.event_code, want.event_code);
            if (got.forward_on !== want.forward_on)
               report_mismatch("forward_on", got.forward_on, want.forward_on);
            if (got.duty_setting !== want.duty_setting)
               report_mismatch("duty_setting", got.duty_setting, want.duty_setting);
            if (got.bridge_in1 !== want.bridge_in1)
               report_mismatch("bridge_in1", got.bridge_in1, want.bridge_in1);
            if (got.bridge_in2 !== want.bridge_in2)
               report_mismatch("bridge_in2", got.bridge_in2, want.bridge_in2);
            if (got.enable_duty !== want.enable_duty)
               report_mismatch("enable_duty", got.enable_duty, want.enable_duty);
         end
      end
   end

   task automatic send_item(req_kind_type kind, logic [7:0] ch);
      int gap;
      if (tx_gaps_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 17);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      items_used += parse_item(kind, ch);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_item(REQ_BYTE, s[i]);
   endtask

   task automatic tick_until_run();
      while (pend_count != 0)
         send_item(REQ_TICK, 8'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (command_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_idle_limit(logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      idle_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] command_letter();
      case ($urandom_range(0, 6))
         0: return CH_F_UP;
         1: return CH_F_LO;
         2: return CH_S_UP;
         3: return CH_S_LO;
         4: return CH_QUERY;
         5: return CH_H_UP;
         default: return CH_H_LO;
      endcase
   endfunction

   function automatic logic [7:0] unprintable_byte();
      logic [7:0] b;
      if ($urandom_range(0, 1)) begin
         b = 8'($urandom_range(0, 31));
         if (b == CH_CR || b == CH_LF)
            b = 8'h00;
      end else begin
         b = 8'($urandom_range(127, 255));
      end
      return b;
   endfunction

   // body character, now and then spoilt by line noise or a stray tick
   task automatic send_body_char(logic [7:0] ch);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         send_item(REQ_BYTE, unprintable_byte());
      else if (pick == 1)
         send_item(REQ_TICK, 8'($urandom));
      send_item(REQ_BYTE, ch);
   endtask

   task automatic send_random_command();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         len = $urandom_range(1, 4);
         repeat (len) begin
            if ($urandom_range(0, 1))
               send_item(REQ_TICK, 8'($urandom));
            else
               send_item(REQ_BYTE, 8'($urandom));
         end
         return;
      end
      if (pick < 40) begin
         send_item(REQ_BYTE, command_letter());
         len = $urandom_range(0, 3);
         repeat (len) send_body_char(8'($urandom_range(32, 126)));
      end else if (pick < 75) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
         repeat (len) send_body_char(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (pick < 85) begin
         len = $urandom_range(1, 3);
         repeat (len) send_body_char(CH_ZERO + 8'($urandom_range(0, 9)));
         len = $urandom_range(1, 3);
         repeat (len) send_body_char(8'($urandom_range(32, 126)));
      end else begin
         len = $urandom_range(1, 5);
         repeat (len) send_body_char(8'($urandom_range(32, 126)));
      end
      if (idle_limit <= 40 && $urandom_range(0, 2) == 0)
         tick_until_run();
      else
         send_item(REQ_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   task automatic test_directed();
      send_item(REQ_BYTE, CH_CR);
      send_item(REQ_TICK, 8'hFF);
      send_item(REQ_BYTE, 8'h00);
      send_item(REQ_BYTE, 8'hFF);
      send_text("f\n");
      send_text("9999\r");
      send_text("H\r");
      send_text("?\n");
      send_text("~ \r");
      send_text("S\r");
      send_text("F0\r");
      send_text("0\r");
   endtask

   task automatic test_full_command();
      // bytes past the eleventh are dropped
      send_text("12345678901xyz\r");
      send_text("abcdefghijkl5\n");
      send_text("F123456789012345\r");
   endtask

   task automatic test_idle_timeout();
      // limit left at its reset value
      send_text("1");
      tick_until_run();
      write_idle_limit(16'd3);
      send_text("5");
      send_item(REQ_TICK, 8'h00);
      send_item(REQ_TICK, 8'h00);
      send_item(REQ_BYTE, 8'h07);
      send_item(REQ_BYTE, 8'h80);
      send_item(REQ_TICK, 8'h00);
      send_text("F1234567890");
      send_item(REQ_TICK, 8'h00);
      send_item(REQ_TICK, 8'h00);
      send_text("zz");
      send_item(REQ_TICK, 8'h00);
      write_idle_limit(16'd1);
      send_text("s");
      send_item(REQ_TICK, 8'h00);
      write_idle_limit(16'd0);
      send_text("h");
      send_item(REQ_TICK, 8'h00);
      write_idle_limit(16'hFFFF);
      tx_gaps_on = 1'b0;
      send_text("7");
      repeat (6) send_item(REQ_TICK, 8'h00);
      send_item(REQ_BYTE, CH_CR);
      tx_gaps_on = 1'b1;
      write_idle_limit(16'd80);
   endtask

   task automatic test_output_hold();
      tx_gaps_on = 1'b0;
      rx_stalls_on = 1'b0;
      hold_left = 150;
      repeat (12) begin
         send_text("F\r");
         send_text("42\n");
      end
      wait_drained();
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (3) begin
         repeat (3) send_random_command();
         wait_drained();
      end
   endtask

   task automatic test_random();
      int target;
      int next_cfg;
      target = items_used + RANDOM_ITEMS;
      next_cfg = items_used + 200;
      while (items_used < target) begin
         if (items_used >= next_cfg && pend_count == 0) begin
            case ($urandom_range(0, 9))
               0: write_idle_limit(16'd80);
               1: write_idle_limit(16'($urandom_range(1, 65535)));
               2: write_idle_limit(16'd1);
               default: write_idle_limit(16'($urandom_range(1, 8)));
            endcase
            next_cfg += 200;
         end
         // closing stretch at full rate on both sides
         if (items_used >= target - 150) begin
            tx_gaps_on = 1'b0;
            rx_stalls_on = 1'b0;
         end
         send_random_command();
      end
      if (pend_count != 0)
         send_item(REQ_BYTE, CH_CR);
   endtask

   initial begin
      clear_command();
      motor_fwd  = 1'b0;
      motor_duty = '0;
      idle_limit = IDLE_RESET;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_command();
      test_idle_timeout();
      test_output_hold();
      test_sender_pause();
      test_random();
      wait_drained();
      repeat (10) @(posedge clock);
      if (command_results_q.size() != 0)
         report_mismatch("results never seen", command_results_q.size(), 0);
      if (mismatches == 0)
         $display("serial_motor_command_parser_tb: done, clean");
      else
         $display("serial_motor_command_parser_tb: done, errors");
      $finish;
   end

endmodule
